FILE: sv/ldd_pkg.sv
`default_nettype none
package ldd_pkg;

  localparam int TagW = 64;
  localparam int IdxW = 5;

  localparam logic [1:0] FuncIntent  = 2'd0;
  localparam logic [1:0] FuncAcquire = 2'd1;
  localparam logic [1:0] FuncRelease = 2'd2;
  localparam logic [1:0] FuncNone    = 2'd3;

  localparam logic [1:0] StatOk         = 2'd0;
  localparam logic [1:0] StatNullLock   = 2'd1;
  localparam logic [1:0] StatThreadFull = 2'd2;
  localparam logic [1:0] StatLockFull   = 2'd3;

  // Queued item with the classification done at the front
  typedef struct packed {
    logic [1:0]      func;
    logic [TagW-1:0] thread_tag;
    logic [TagW-1:0] lock_tag;
    logic            nop;
    logic            null_lock;
  } ldd_item_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [IdxW-1:0] thread_index;
    logic [IdxW-1:0] lock_index;
    logic            cycle_closed;
    logic            first_report;
    logic [IdxW-1:0] held_lock_index;
  } ldd_result_t;

endpackage
`default_nettype wire

FILE: sv/ldd_front.sv
`default_nettype none
module ldd_front (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire  [1:0]               in_func,
  input  wire  [63:0]              in_thread_tag,
  input  wire  [63:0]              in_lock_tag,
  output logic                     q_valid,
  input  wire                      q_ready,
  output ldd_pkg::ldd_item_t       q_item
);
  import ldd_pkg::*;

  ldd_item_t  slot_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  ldd_item_t  cls;
  logic       push, pop;

  // Classify the incoming item
  always_comb begin
    cls.func       = in_func;
    cls.thread_tag = in_thread_tag;
    cls.lock_tag   = in_lock_tag;
    cls.nop        = (in_func == FuncNone);
    cls.null_lock  = (in_lock_tag == '0);
  end

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = slot_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // Advance queue pointers
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= cls;
    end
  end

endmodule
`default_nettype wire

FILE: sv/ldd_back.sv
`default_nettype none
module ldd_back #(
  parameter int LOCK_SLOTS   = 32,
  parameter int THREAD_SLOTS = 32
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      q_valid,
  output logic                     q_ready,
  input  wire ldd_pkg::ldd_item_t  q_item,
  output logic                     res_valid,
  input  wire                      res_ready,
  output ldd_pkg::ldd_result_t     res
);
  import ldd_pkg::*;

  localparam int TIW  = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam int LIW  = $clog2(LOCK_SLOTS);
  localparam int MaxS = (THREAD_SLOTS > LOCK_SLOTS) ? THREAD_SLOTS : LOCK_SLOTS;
  localparam int CW   = $clog2(MaxS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TRD   = 4'd1;
  localparam logic [3:0] S_TCMP  = 4'd2;
  localparam logic [3:0] S_NULL  = 4'd3;
  localparam logic [3:0] S_LRD   = 4'd4;
  localparam logic [3:0] S_LCMP  = 4'd5;
  localparam logic [3:0] S_HWAIT = 4'd6;
  localparam logic [3:0] S_ISEL  = 4'd7;
  localparam logic [3:0] S_EWAIT = 4'd8;
  localparam logic [3:0] S_BSEL  = 4'd9;
  localparam logic [3:0] S_BWAIT = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  // Memories
  logic [TagW-1:0]       ttag_mem [THREAD_SLOTS];
  logic [TagW-1:0]       ltag_mem [LOCK_SLOTS];
  logic [LOCK_SLOTS-1:0] held_mem [THREAD_SLOTS];
  logic [LOCK_SLOTS-1:0] edge_mem [LOCK_SLOTS];
  logic [THREAD_SLOTS-1:0] hvalid_r;
  logic [LOCK_SLOTS-1:0]   evalid_r;
  logic [TagW-1:0]       trd_r, lrd_r;
  logic [LOCK_SLOTS-1:0] hrd_r, erd_r;
  logic                  hrd_v_r, erd_v_r;

  // Memory port controls
  logic                  t_we, l_we, h_we, e_we, h_re, e_re;
  logic [TIW-1:0]        t_addr, h_addr;
  logic [LIW-1:0]        l_addr, e_addr;
  logic [LOCK_SLOTS-1:0] h_wdata, e_wdata;

  logic [3:0]            state_r, state_nxt;
  ldd_item_t             item_r, item_nxt;
  logic [CW-1:0]         k_r, k_nxt, tcnt_r, tcnt_nxt, lcnt_r, lcnt_nxt;
  logic [TIW-1:0]        tid_r, tid_nxt;
  logic [LIW-1:0]        lid_r, lid_nxt, i_r, i_nxt;
  logic [1:0]            stat_r, stat_nxt;
  logic [LOCK_SLOTS-1:0] pend_r, pend_nxt, reach_r, reach_nxt, proc_r, proc_nxt;
  logic                  seen_r, seen_nxt, cyc_r, cyc_nxt, first_r, first_nxt;
  logic                  ov_r, ov_nxt;
  ldd_result_t           res_r, res_nxt;

  logic [LOCK_SLOTS-1:0] lbit, hrow, erow, front_set;
  logic [TIW+IdxW-1:0]   tid_ext;
  logic [LIW+IdxW-1:0]   lid_ext, hidx_ext;

  function automatic logic [LIW-1:0] lowest(input logic [LOCK_SLOTS-1:0] v);
    logic [LIW-1:0] r;
    r = '0;
    for (int n = LOCK_SLOTS - 1; n >= 0; n--) begin
      if (v[n]) r = LIW'(n);
    end
    return r;
  endfunction

  assign lbit      = {{(LOCK_SLOTS-1){1'b0}}, 1'b1} << lid_r;
  assign hrow      = hrd_v_r ? hrd_r : '0;
  assign erow      = erd_v_r ? erd_r : '0;
  assign front_set = reach_r & ~proc_r;
  assign tid_ext   = {{IdxW{1'b0}}, tid_r};
  assign lid_ext   = {{IdxW{1'b0}}, lid_r};
  assign hidx_ext  = {{IdxW{1'b0}}, i_r};
  assign q_ready   = (state_r == S_IDLE);
  assign res_valid = ov_r;
  assign res       = res_r;

  // Sequence one item through lookup, update and the order check
  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    k_nxt     = k_r;
    tcnt_nxt  = tcnt_r;
    lcnt_nxt  = lcnt_r;
    tid_nxt   = tid_r;
    lid_nxt   = lid_r;
    i_nxt     = i_r;
    stat_nxt  = stat_r;
    pend_nxt  = pend_r;
    reach_nxt = reach_r;
    proc_nxt  = proc_r;
    seen_nxt  = seen_r;
    cyc_nxt   = cyc_r;
    first_nxt = first_r;
    ov_nxt    = ov_r && !res_ready;
    res_nxt   = res_r;
    t_we = 1'b0; l_we = 1'b0; h_we = 1'b0; e_we = 1'b0; h_re = 1'b0; e_re = 1'b0;
    t_addr  = k_r[TIW-1:0];
    l_addr  = k_r[LIW-1:0];
    h_addr  = tid_r;
    e_addr  = i_r;
    h_wdata = hrow;
    e_wdata = erow | lbit;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          item_nxt  = q_item;
          k_nxt     = '0;
          tid_nxt   = '0;
          lid_nxt   = '0;
          stat_nxt  = StatOk;
          cyc_nxt   = 1'b0;
          first_nxt = 1'b0;
          i_nxt     = '0;
          state_nxt = q_item.nop ? S_OUT : S_TRD;
        end
      end
      S_TRD: begin
        if (k_r == tcnt_r) begin
          if (tcnt_r == CW'(THREAD_SLOTS)) begin
            stat_nxt  = StatThreadFull;
            state_nxt = S_OUT;
          end else begin
            t_we      = 1'b1;
            t_addr    = tcnt_r[TIW-1:0];
            tid_nxt   = tcnt_r[TIW-1:0];
            tcnt_nxt  = tcnt_r + 1'b1;
            state_nxt = S_NULL;
          end
        end else begin
          state_nxt = S_TCMP;
        end
      end
      S_TCMP: begin
        if (trd_r == item_r.thread_tag) begin
          tid_nxt   = k_r[TIW-1:0];
          state_nxt = S_NULL;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_TRD;
        end
      end
      S_NULL: begin
        k_nxt = '0;
        if (item_r.null_lock) begin
          stat_nxt  = StatNullLock;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_LRD;
        end
      end
      S_LRD: begin
        if (k_r == lcnt_r) begin
          if (lcnt_r == CW'(LOCK_SLOTS)) begin
            stat_nxt  = StatLockFull;
            state_nxt = S_OUT;
          end else begin
            l_we      = 1'b1;
            l_addr    = lcnt_r[LIW-1:0];
            lid_nxt   = lcnt_r[LIW-1:0];
            lcnt_nxt  = lcnt_r + 1'b1;
            h_re      = 1'b1;
            state_nxt = S_HWAIT;
          end
        end else begin
          state_nxt = S_LCMP;
        end
      end
      S_LCMP: begin
        if (lrd_r == item_r.lock_tag) begin
          lid_nxt   = k_r[LIW-1:0];
          h_re      = 1'b1;
          state_nxt = S_HWAIT;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_LRD;
        end
      end
      S_HWAIT: begin
        if (item_r.func == FuncAcquire) begin
          h_we      = 1'b1;
          h_wdata   = hrow | lbit;
          state_nxt = S_OUT;
        end else if (item_r.func == FuncRelease) begin
          h_we      = 1'b1;
          h_wdata   = hrow & ~lbit;
          state_nxt = S_OUT;
        end else begin
          pend_nxt  = hrow;
          state_nxt = S_ISEL;
        end
      end
      S_ISEL: begin
        if (pend_r == '0) begin
          i_nxt     = '0;
          state_nxt = S_OUT;
        end else begin
          i_nxt     = lowest(pend_r);
          e_addr    = i_nxt;
          e_re      = 1'b1;
          pend_nxt  = pend_r & ~({{(LOCK_SLOTS-1){1'b0}}, 1'b1} << i_nxt);
          state_nxt = S_EWAIT;
        end
      end
      S_EWAIT: begin
        if ((erow & lbit) != '0) begin
          state_nxt = S_ISEL;
        end else begin
          e_we      = 1'b1;
          reach_nxt = lbit;
          proc_nxt  = '0;
          state_nxt = S_BSEL;
        end
      end
      S_BSEL: begin
        if (front_set == '0) begin
          if (reach_r[i_r]) begin
            cyc_nxt   = 1'b1;
            first_nxt = !seen_r;
            seen_nxt  = 1'b1;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_ISEL;
          end
        end else begin
          e_addr    = lowest(front_set);
          e_re      = 1'b1;
          proc_nxt  = proc_r | ({{(LOCK_SLOTS-1){1'b0}}, 1'b1} << e_addr);
          state_nxt = S_BWAIT;
        end
      end
      S_BWAIT: begin
        reach_nxt = reach_r | erow;
        state_nxt = S_BSEL;
      end
      S_OUT: begin
        if (!ov_r || res_ready) begin
          ov_nxt                  = 1'b1;
          res_nxt.status          = stat_r;
          res_nxt.thread_index    = tid_ext[IdxW-1:0];
          res_nxt.lock_index      = (stat_r == StatOk) ? lid_ext[IdxW-1:0] : '0;
          res_nxt.cycle_closed    = cyc_r;
          res_nxt.first_report    = first_r;
          res_nxt.held_lock_index = cyc_r ? hidx_ext[IdxW-1:0] : '0;
          state_nxt               = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      tcnt_r   <= '0;
      lcnt_r   <= '0;
      seen_r   <= 1'b0;
      ov_r     <= 1'b0;
      hvalid_r <= '0;
      evalid_r <= '0;
    end else begin
      state_r <= state_nxt;
      tcnt_r  <= tcnt_nxt;
      lcnt_r  <= lcnt_nxt;
      seen_r  <= seen_nxt;
      ov_r    <= ov_nxt;
      if (h_we) hvalid_r[h_addr] <= 1'b1;
      if (e_we) evalid_r[e_addr] <= 1'b1;
    end
  end

  // Hold working payload
  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    k_r     <= k_nxt;
    tid_r   <= tid_nxt;
    lid_r   <= lid_nxt;
    i_r     <= i_nxt;
    stat_r  <= stat_nxt;
    pend_r  <= pend_nxt;
    reach_r <= reach_nxt;
    proc_r  <= proc_nxt;
    cyc_r   <= cyc_nxt;
    first_r <= first_nxt;
    res_r   <= res_nxt;
  end

  // Tag tables
  always_ff @(posedge clk) begin
    if (t_we) ttag_mem[t_addr] <= item_r.thread_tag;
    trd_r <= ttag_mem[t_addr];
  end

  always_ff @(posedge clk) begin
    if (l_we) ltag_mem[l_addr] <= item_r.lock_tag;
    lrd_r <= ltag_mem[l_addr];
  end

  // Held-lock sets, one row per thread
  always_ff @(posedge clk) begin
    if (h_we) held_mem[h_addr] <= h_wdata;
    if (h_re) begin
      hrd_r   <= held_mem[h_addr];
      hrd_v_r <= hvalid_r[h_addr];
    end
  end

  // Lock-order matrix, one row per lock
  always_ff @(posedge clk) begin
    if (e_we) edge_mem[e_addr] <= e_wdata;
    if (e_re) begin
      erd_r   <= edge_mem[e_addr];
      erd_v_r <= evalid_r[e_addr];
    end
  end

endmodule
`default_nettype wire

FILE: sv/lock_order_deadlock_detector_core.sv
`default_nettype none
// Lock-order deadlock detector. Each item is one lock event (intent, acquired,
// released) from a thread; exactly one result item comes back per event, in
// order. A two-entry queue takes items while the engine works. The engine scans
// the thread and lock tag tables one slot at a time, reading a tag and then
// comparing it; an intent adds, per held lock whose order edge is new, a
// reachability walk over the order-matrix memory (one row read per step).
// Tag slots are never freed.
module lock_order_deadlock_detector_core #(
  parameter int LOCK_SLOTS   = 32,
  parameter int THREAD_SLOTS = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  in_func,
  input  wire  [63:0] in_thread_tag,
  input  wire  [63:0] in_lock_tag,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [1:0]  out_status,
  output logic [4:0]  out_thread_index,
  output logic [4:0]  out_lock_index,
  output logic        out_cycle_closed,
  output logic        out_first_report,
  output logic [4:0]  out_held_lock_index
);
  import ldd_pkg::*;

  logic        q_valid, q_ready;
  ldd_item_t   q_item;
  ldd_result_t res;

  ldd_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_func, .in_thread_tag, .in_lock_tag,
    .q_valid, .q_ready, .q_item
  );

  ldd_back #(.LOCK_SLOTS(LOCK_SLOTS), .THREAD_SLOTS(THREAD_SLOTS)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_item,
    .res_valid(out_valid), .res_ready(out_ready), .res
  );

  assign out_status          = res.status;
  assign out_thread_index    = res.thread_index;
  assign out_lock_index      = res.lock_index;
  assign out_cycle_closed    = res.cycle_closed;
  assign out_first_report    = res.first_report;
  assign out_held_lock_index = res.held_lock_index;

`ifndef ASSERT_OFF
  a_cyc_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cycle_closed |-> out_status == StatOk)
    else $error("cycle reported on an error status");
  a_first_cyc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_first_report |-> out_cycle_closed)
    else $error("first report without a cycle");
  a_err_lock: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != StatOk |-> out_lock_index == 5'd0)
    else $error("lock index set on an error status");
`endif

endmodule
`default_nettype wire
